/* rtl/xmpcu_pkg.sv */
// Package for the pattern cell unpacker: cell record type, phase codes,
// limits and small decode helpers. Depends on nothing.
`default_nettype none

package xmpcu_pkg;

   localparam int MAX_CHANNELS = 32;
   localparam int MAX_ROWS     = 256;
   localparam int CH_LIMIT     = (MAX_CHANNELS < 32) ? MAX_CHANNELS : 32;

   localparam logic [3:0] HDR_ROWS_LO = 4'd5;
   localparam logic [3:0] HDR_ROWS_HI = 4'd6;
   localparam logic [3:0] HDR_LAST    = 4'd8;

   localparam logic       CSR_CHANNEL_COUNT = 1'b0;
   localparam logic [5:0] CHANNEL_COUNT_RESET = 6'd4;

   localparam logic [4:0] NOTE_FOLLOWS_MASK = 5'b11110;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_LEAD   = 3'b010,
      PH_FIELD  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] note;
      logic [7:0] instrument;
      logic [7:0] volume;
      logic [7:0] effect;
      logic [7:0] effect_param;
      logic [4:0] channel_index;
      logic [7:0] row_index;
      logic       row_end;
      logic       pattern_end;
   } cell_type;

   function automatic logic [2:0] lowest_set(input logic [4:0] m);
      logic [2:0] r;
      r = 3'd0;
      for (int i = 4; i >= 0; i--) begin
         if (m[i]) r = 3'(i);
      end
      return r;
   endfunction

   // index of the last active channel
   function automatic logic [4:0] last_channel(input logic [5:0] cc);
      logic [6:0] c;
      c = {1'b0, cc};
      if (c == 7'd0) c = 7'd1;
      if (c > 7'(CH_LIMIT)) c = 7'(CH_LIMIT);
      return 5'(c - 7'd1);
   endfunction

endpackage

`default_nettype wire

/* rtl/xm_pattern_cell_unpacker_top.sv */
// Pattern cell unpacker top level: byte stream in, cell records out.
// Depends on xmpcu_pkg, xmpcu_csr, xmpcu_parser, xmpcu_out_reg.
//
// Usage:
//   req_* : one pattern byte per transfer (tdata[7:0] = data_byte).
//   rsp_* : one cell per transfer; tlast marks the final cell of a pattern,
//           tuser[0] marks the last channel of a row.
//   csr_* : APB-style port; channel_count at address 0, pready always high.
// Each pattern starts with a 9-byte header holding the row count at bytes
// 5..6; then rows x channels cells follow.
// Latency: a cell appears on rsp_* in the cycle after its last byte transfer.
// Throughput: one byte per cycle, set by the single result register; the
// input is taken while a held cell is being transferred out.
// Stall: when rsp_tready is low and a cell is held, req_tready drops.
// Reset: synchronous; parser returns to header phase, result register
// empties, channel_count returns to 4.
`default_nettype none

module xm_pattern_cell_unpacker_top
   import xmpcu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] note, [15:8] instrument, [23:16] volume, [31:24] effect,
   // [39:32] effect_param, [44:40] channel_index, [52:45] row_index, zero fill
   output logic      [55:0] rsp_tdata,
   output logic      [0:0]  rsp_tuser,   // [0] row_end
   output logic             rsp_tlast,   // pattern_end
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   logic     [5:0] channel_count;
   logic           byte_accept;
   logic           cell_valid;
   logic           out_free;
   cell_type       cell_new;
   cell_type       cell_held;

   xmpcu_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .channel_count (channel_count)
   );

   assign req_tready  = out_free;
   assign byte_accept = req_tvalid && out_free;

   xmpcu_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .byte_accept   (byte_accept),
      .data_byte     (req_tdata),
      .channel_count (channel_count),
      .cell_valid    (cell_valid),
      .cell_rec      (cell_new)
   );

   xmpcu_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (cell_valid),
      .cell_in  (cell_new),
      .take     (rsp_tready),
      .valid    (rsp_tvalid),
      .free     (out_free),
      .cell_out (cell_held)
   );

   assign rsp_tdata = {3'd0, cell_held.row_index, cell_held.channel_index,
                       cell_held.effect_param, cell_held.effect, cell_held.volume,
                       cell_held.instrument, cell_held.note};
   assign rsp_tuser = cell_held.row_end;
   assign rsp_tlast = cell_held.pattern_end;

endmodule

`default_nettype wire

/* rtl/xmpcu_csr.sv */
// APB-style register file holding the channel count.
// Depends on xmpcu_pkg.
`default_nettype none

module xmpcu_csr
   import xmpcu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output logic      [5:0]  channel_count
);

   logic [5:0] channel_count_ff;
   logic [5:0] channel_count_in;
   logic       sel_cc;

   assign sel_cc = (csr_paddr[2] == CSR_CHANNEL_COUNT);

   always_comb begin
      channel_count_in = channel_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_cc)
         channel_count_in = csr_pwdata[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) channel_count_ff <= CHANNEL_COUNT_RESET;
      else       channel_count_ff <= channel_count_in;
   end

   assign csr_pready    = 1'b1;
   assign csr_prdata    = sel_cc ? {26'd0, channel_count_ff} : 32'd0;
   assign channel_count = channel_count_ff;

   logic unused_addr;
   assign unused_addr = ^{csr_paddr[1:0], csr_pwdata[31:6]};

endmodule

`default_nettype wire

/* rtl/xmpcu_parser.sv */
// Header parser and cell assembler: one byte per transfer, emits a cell
// record when a cell completes. Depends on xmpcu_pkg.
`default_nettype none

module xmpcu_parser
   import xmpcu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_accept,
   input  wire logic [7:0] data_byte,
   input  wire logic [5:0] channel_count,
   output logic            cell_valid,
   output cell_type        cell_rec
);

   phase_type  phase_ff, phase_in;
   logic [3:0] header_count_ff, header_count_in;
   logic [15:0] rows_total_ff, rows_total_in;
   logic [4:0] field_mask_ff, field_mask_in;
   logic [2:0] field_position_ff, field_position_in;
   logic [7:0] cell_bytes_ff [5];
   logic [7:0] cell_bytes_in [5];
   logic [4:0] channel_counter_ff, channel_counter_in;
   logic [7:0] row_counter_ff, row_counter_in;

   logic       do_emit;
   logic       rend;
   logic       pend;
   logic [4:0] last_ch;
   logic [4:0] mask_left;

   always_comb begin
      phase_in           = phase_ff;
      header_count_in    = header_count_ff;
      rows_total_in      = rows_total_ff;
      field_mask_in      = field_mask_ff;
      field_position_in  = field_position_ff;
      channel_counter_in = channel_counter_ff;
      row_counter_in     = row_counter_ff;
      for (int i = 0; i < 5; i++) cell_bytes_in[i] = cell_bytes_ff[i];
      do_emit   = 1'b0;
      mask_left = field_mask_ff;

      unique case (phase_ff)
         PH_LEAD: begin
            for (int i = 0; i < 5; i++) cell_bytes_in[i] = 8'd0;
            if (data_byte[7]) begin
               field_mask_in = data_byte[4:0];
               if (data_byte[4:0] == 5'd0) do_emit = 1'b1;
            end else begin
               cell_bytes_in[0] = data_byte;
               field_mask_in    = NOTE_FOLLOWS_MASK;
            end
            if (!do_emit) begin
               field_position_in = lowest_set(field_mask_in);
               phase_in          = PH_FIELD;
            end
         end
         PH_FIELD: begin
            for (int i = 0; i < 5; i++) begin
               if (3'(i) == field_position_ff) begin
                  cell_bytes_in[i] = data_byte;
                  mask_left[i]     = 1'b0;
               end
            end
            field_mask_in = mask_left;
            if (mask_left == 5'd0) do_emit = 1'b1;
            else field_position_in = lowest_set(mask_left);
         end
         default: begin
            phase_in = PH_HEADER;
            if (header_count_ff == HDR_ROWS_LO)
               rows_total_in = {rows_total_ff[15:8], data_byte};
            else if (header_count_ff == HDR_ROWS_HI)
               rows_total_in = {data_byte, rows_total_ff[7:0]};
            if (header_count_ff >= HDR_LAST) begin
               header_count_in    = 4'd0;
               channel_counter_in = 5'd0;
               row_counter_in     = 8'd0;
               field_mask_in      = 5'd0;
               field_position_in  = 3'd0;
               if (rows_total_in != 16'd0 && {1'b0, rows_total_in} <= 17'(MAX_ROWS))
                  phase_in = PH_LEAD;
            end else begin
               header_count_in = header_count_ff + 4'd1;
            end
         end
      endcase

      last_ch = last_channel(channel_count);
      rend    = (channel_counter_ff >= last_ch);
      pend    = rend && ({8'd0, ({1'b0, row_counter_ff} + 9'd1)} >= {1'b0, rows_total_ff});

      if (do_emit) begin
         field_mask_in     = 5'd0;
         field_position_in = 3'd0;
         if (pend) begin
            phase_in           = PH_HEADER;
            header_count_in    = 4'd0;
            channel_counter_in = 5'd0;
            row_counter_in     = 8'd0;
         end else begin
            phase_in = PH_LEAD;
            if (rend) begin
               channel_counter_in = 5'd0;
               row_counter_in     = row_counter_ff + 8'd1;
            end else begin
               channel_counter_in = channel_counter_ff + 5'd1;
            end
         end
      end
   end

   always_comb begin
      cell_rec.note          = cell_bytes_in[0];
      cell_rec.instrument    = cell_bytes_in[1];
      cell_rec.volume        = cell_bytes_in[2];
      cell_rec.effect        = cell_bytes_in[3];
      cell_rec.effect_param  = cell_bytes_in[4];
      cell_rec.channel_index = channel_counter_ff;
      cell_rec.row_index     = row_counter_ff;
      cell_rec.row_end       = rend;
      cell_rec.pattern_end   = pend;
   end

   assign cell_valid = byte_accept && do_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HEADER;
         header_count_ff    <= 4'd0;
         rows_total_ff      <= 16'd0;
         field_mask_ff      <= 5'd0;
         field_position_ff  <= 3'd0;
         channel_counter_ff <= 5'd0;
         row_counter_ff     <= 8'd0;
      end else if (byte_accept) begin
         phase_ff           <= phase_in;
         header_count_ff    <= header_count_in;
         rows_total_ff      <= rows_total_in;
         field_mask_ff      <= field_mask_in;
         field_position_ff  <= field_position_in;
         channel_counter_ff <= channel_counter_in;
         row_counter_ff     <= row_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) cell_bytes_ff[i] <= 8'd0;
      end else if (byte_accept) begin
         for (int i = 0; i < 5; i++) cell_bytes_ff[i] <= cell_bytes_in[i];
      end
   end

endmodule

`default_nettype wire

/* rtl/xmpcu_out_reg.sv */
// Result register for one cell record with valid/ready handshake.
// Depends on xmpcu_pkg.
`default_nettype none

module xmpcu_out_reg
   import xmpcu_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     load,
   input  wire cell_type cell_in,
   input  wire logic     take,
   output logic          valid,
   output logic          free,
   output cell_type      cell_out
);

   logic     valid_ff, valid_in;
   cell_type cell_ff;

   assign free = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (take) valid_in = 1'b0;
      if (load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) cell_ff <= cell_in;
   end

   assign valid    = valid_ff;
   assign cell_out = cell_ff;

endmodule

`default_nettype wire
